@@ rtl/lpst_pkg.sv @@
// lpst_pkg: shared types and constants of the led pwm sequence ticker
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lpst_pkg;

    // fixed field widths
    localparam int MODE_W     = 2;
    localparam int CHAN_W     = 3;
    localparam int ADDR_W     = 8;
    localparam int DATA_W     = 8;
    localparam int LED_W      = 8;
    localparam int LED_IDX_W  = 3;
    localparam int LIT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PERIOD_W   = 8;
    localparam int SEC_W      = 16;
    localparam int TMO_W      = 8;

    // input item operations
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_S = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_SECONDS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TMO_PRESC   = 2'd3;

    // configuration reset values
    localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD  = 8'd25;
    localparam logic [SEC_W-1:0]    RST_TICKS_PER_S = 16'd2500;
    localparam logic [SEC_W-1:0]    RST_OFF_SECONDS = 16'd900;
    localparam logic [TMO_W-1:0]    RST_TMO_PRESC   = 8'd100;

    // result of one channel step of the shared unit
    typedef struct packed {
        logic [PERIOD_W-1:0] cnt_inc;
        logic [ADDR_W-1:0]   addr_inc;
        logic                hit_on;
        logic                wrap;
    } lpst_alu_res_t;

endpackage

`default_nettype wire

@@ rtl/led_pwm_sequence_ticker.sv @@
// led_pwm_sequence_ticker: top level, sequencer, channel state and timers
// depends on lpst_pkg, lpst_pattern_ram and lpst_chan_alu
`timescale 1ns / 1ps
`default_nettype none

// An item is taken when start is high and busy is low. A tick walks the
// channels one after another through one shared step unit: an idle channel
// or an active one within its pwm period is handled in the channel state,
// and an active one whose pwm period ends also passes the fetch state to
// read its next entry from the registered read port of the pattern memory.
// A bookkeeping state for the timeout and seconds countdowns follows. A
// start, a pattern write or a timeout load also keeps busy high. The
// result comes in the first cycle with busy low again, marked by done for
// exactly one cycle; the receiver cannot stall it, and a new item may be
// started in that same cycle. The result ports are only meaningful while
// done is high; while busy is high they follow the working state.
// Configuration writes are taken only while busy is low (cfg_ready).
// The pattern memory has no reset; reading an entry never written gives an
// unspecified on-time.
module led_pwm_sequence_ticker
    import lpst_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int TABLE_DEPTH  = 256
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // command side
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [CHAN_W-1:0]     channel,
    input  wire logic [ADDR_W-1:0]     address,
    input  wire logic [DATA_W-1:0]     data,

    // result side, one transaction per item
    output logic                       done,
    output logic [LED_W-1:0]           led_state,
    output logic [LIT_W-1:0]           leds_lit_count,
    output logic [TMO_W-1:0]           timeout_left,
    output logic                       power_off,

    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int AW   = $clog2(TABLE_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_START_RD   = 3'd1;
    localparam logic [2:0] S_TICK_CH    = 3'd2;
    localparam logic [2:0] S_TICK_FETCH = 3'd3;
    localparam logic [2:0] S_TICK_TMR   = 3'd4;
    localparam logic [2:0] S_FINISH     = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CH_W-1:0]     idx_reg, idx_next;
    logic                rd_ok_reg, rd_ok_next;
    logic                done_reg, done_next;
    logic                pulse_reg, pulse_next;

    // per-channel state, each read only at the current channel pointer
    logic [ADDR_W-1:0]   chan_addr_reg    [NUM_CHANNELS];
    logic [ADDR_W-1:0]   chan_addr_next   [NUM_CHANNELS];
    logic [PERIOD_W-1:0] chan_count_reg   [NUM_CHANNELS];
    logic [PERIOD_W-1:0] chan_count_next  [NUM_CHANNELS];
    logic [PERIOD_W-1:0] chan_on_reg      [NUM_CHANNELS];
    logic [PERIOD_W-1:0] chan_on_next     [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] chan_active_reg, chan_active_next;

    logic [LED_W-1:0]    led_bits_reg, led_bits_next;
    logic [LIT_W-1:0]    lit_count_reg, lit_count_next;

    // countdowns
    logic [SEC_W-1:0]    tick_presc_reg, tick_presc_next;
    logic [SEC_W-1:0]    seconds_reg, seconds_next;
    logic [TMO_W-1:0]    tmo_presc_reg, tmo_presc_next;
    logic [TMO_W-1:0]    tmo_value_reg, tmo_value_next;

    // configuration registers
    logic [PERIOD_W-1:0] pwm_period_reg, pwm_period_next;
    logic [SEC_W-1:0]    ticks_per_s_reg, ticks_per_s_next;
    logic [TMO_W-1:0]    tmo_presc_cfg_reg, tmo_presc_cfg_next;

    // memory port
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;
    logic [DATA_W-1:0]   entry;

    lpst_alu_res_t       alu;
    logic                chan_ok;
    logic                addr_ok;
    logic                fetch_ok;
    logic                last_ch;
    logic [LED_IDX_W-1:0] led_idx;
    logic [TMO_W-1:0]    tmo_p_inc;
    logic [SEC_W-1:0]    tick_p_inc;

    lpst_pattern_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (address[AW-1:0]),
        .wdata (data),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lpst_chan_alu u_alu (
        .count   (chan_count_reg[idx_reg]),
        .on_time (chan_on_reg[idx_reg]),
        .period  (pwm_period_reg),
        .addr    (chan_addr_reg[idx_reg]),
        .res     (alu)
    );

    // a start names a channel that exists, a write hits the table
    assign chan_ok  = ({1'b0, channel} < 4'(NUM_CHANNELS));
    assign addr_ok  = ({1'b0, address} < 9'(TABLE_DEPTH));
    assign fetch_ok = ({1'b0, alu.addr_inc} < 9'(TABLE_DEPTH));
    assign last_ch  = (idx_reg == CH_W'(NUM_CHANNELS - 1));
    assign led_idx  = LED_IDX_W'(idx_reg);
    // reads past the table end give a zero entry, ending the sequence
    assign entry    = rd_ok_reg ? mem_rdata : '0;
    assign tmo_p_inc  = tmo_presc_reg + TMO_W'(1);
    assign tick_p_inc = tick_presc_reg + SEC_W'(1);

    always_comb
    begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        rd_ok_next         = rd_ok_reg;
        done_next          = 1'b0;
        pulse_next         = pulse_reg;
        chan_addr_next     = chan_addr_reg;
        chan_count_next    = chan_count_reg;
        chan_on_next       = chan_on_reg;
        chan_active_next   = chan_active_reg;
        led_bits_next      = led_bits_reg;
        lit_count_next     = lit_count_reg;
        tick_presc_next    = tick_presc_reg;
        seconds_next       = seconds_reg;
        tmo_presc_next     = tmo_presc_reg;
        tmo_value_next     = tmo_value_reg;
        pwm_period_next    = pwm_period_reg;
        ticks_per_s_next   = ticks_per_s_reg;
        tmo_presc_cfg_next = tmo_presc_cfg_reg;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        mem_raddr          = address[AW-1:0];

        // configuration transaction, only taken while idle
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PWM_PERIOD:  pwm_period_next    = cfg_data[PERIOD_W-1:0];
                CFG_TICKS_PER_S: ticks_per_s_next   = cfg_data;
                CFG_OFF_SECONDS:
                begin
                    seconds_next    = cfg_data;
                    tick_presc_next = '0;
                end
                CFG_TMO_PRESC:   tmo_presc_cfg_next = cfg_data[TMO_W-1:0];
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pulse_next = 1'b0;
                    unique case (mode)
                        MODE_TICK:
                        begin
                            idx_next   = '0;
                            state_next = S_TICK_CH;
                        end
                        MODE_START:
                        begin
                            if (chan_ok)
                            begin
                                idx_next   = channel[CH_W-1:0];
                                chan_addr_next[channel[CH_W-1:0]]  = address;
                                chan_count_next[channel[CH_W-1:0]] = '0;
                                mem_re     = addr_ok;
                                rd_ok_next = addr_ok;
                                state_next = S_START_RD;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        MODE_WRITE:
                        begin
                            mem_we     = addr_ok;
                            state_next = S_FINISH;
                        end
                        MODE_LOAD:
                        begin
                            tmo_value_next = data;
                            tmo_presc_next = '0;
                            state_next     = S_FINISH;
                        end
                        default: ;
                    endcase
                end
            end

            S_START_RD:
            begin
                // first entry decides whether the channel runs
                chan_on_next[idx_reg] = entry;
                if (entry != '0)
                begin
                    if (!chan_active_reg[idx_reg])
                    begin
                        lit_count_next = lit_count_reg + LIT_W'(1);
                    end
                    chan_active_next[idx_reg] = 1'b1;
                    led_bits_next[led_idx]    = 1'b1;
                end
                else
                begin
                    if (chan_active_reg[idx_reg] && (lit_count_reg != '0))
                    begin
                        lit_count_next = lit_count_reg - LIT_W'(1);
                    end
                    chan_active_next[idx_reg] = 1'b0;
                    led_bits_next[led_idx]    = 1'b0;
                end
                state_next = S_IDLE;
                done_next  = 1'b1;
            end

            S_TICK_CH:
            begin
                if (chan_active_reg[idx_reg])
                begin
                    if (alu.hit_on)
                    begin
                        led_bits_next[led_idx] = 1'b0;
                    end
                    if (alu.wrap)
                    begin
                        chan_count_next[idx_reg] = '0;
                        chan_addr_next[idx_reg]  = alu.addr_inc;
                        mem_re     = fetch_ok;
                        mem_raddr  = alu.addr_inc[AW-1:0];
                        rd_ok_next = fetch_ok;
                        state_next = S_TICK_FETCH;
                    end
                    else
                    begin
                        chan_count_next[idx_reg] = alu.cnt_inc;
                        idx_next   = idx_reg + CH_W'(1);
                        state_next = last_ch ? S_TICK_TMR : S_TICK_CH;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CH_W'(1);
                    state_next = last_ch ? S_TICK_TMR : S_TICK_CH;
                end
            end

            S_TICK_FETCH:
            begin
                chan_on_next[idx_reg] = entry;
                if (entry == '0)
                begin
                    // sequence end, led keeps what it had
                    chan_addr_next[idx_reg]   = '0;
                    chan_active_next[idx_reg] = 1'b0;
                    if (lit_count_reg != '0)
                    begin
                        lit_count_next = lit_count_reg - LIT_W'(1);
                    end
                end
                else
                begin
                    led_bits_next[led_idx] = 1'b1;
                end
                idx_next   = idx_reg + CH_W'(1);
                state_next = last_ch ? S_TICK_TMR : S_TICK_CH;
            end

            S_TICK_TMR:
            begin
                if (tmo_value_reg != '0)
                begin
                    if (tmo_p_inc >= tmo_presc_cfg_reg)
                    begin
                        tmo_presc_next = '0;
                        tmo_value_next = tmo_value_reg - TMO_W'(1);
                    end
                    else
                    begin
                        tmo_presc_next = tmo_p_inc;
                    end
                end
                if (tick_p_inc >= ticks_per_s_reg)
                begin
                    tick_presc_next = '0;
                    if (seconds_reg != '0)
                    begin
                        seconds_next = seconds_reg - SEC_W'(1);
                        pulse_next   = (seconds_reg == SEC_W'(1));
                    end
                end
                else
                begin
                    tick_presc_next = tick_p_inc;
                end
                state_next = S_IDLE;
                done_next  = 1'b1;
            end

            S_FINISH:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            idx_reg           <= '0;
            rd_ok_reg         <= 1'b0;
            done_reg          <= 1'b0;
            pulse_reg         <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_addr_reg[i]  <= '0;
                chan_count_reg[i] <= '0;
                chan_on_reg[i]    <= '0;
            end
            chan_active_reg   <= '0;
            led_bits_reg      <= '0;
            lit_count_reg     <= '0;
            tick_presc_reg    <= '0;
            seconds_reg       <= RST_OFF_SECONDS;
            tmo_presc_reg     <= '0;
            tmo_value_reg     <= '0;
            pwm_period_reg    <= RST_PWM_PERIOD;
            ticks_per_s_reg   <= RST_TICKS_PER_S;
            tmo_presc_cfg_reg <= RST_TMO_PRESC;
        end
        else
        begin
            state_reg         <= state_next;
            idx_reg           <= idx_next;
            rd_ok_reg         <= rd_ok_next;
            done_reg          <= done_next;
            pulse_reg         <= pulse_next;
            chan_addr_reg     <= chan_addr_next;
            chan_count_reg    <= chan_count_next;
            chan_on_reg       <= chan_on_next;
            chan_active_reg   <= chan_active_next;
            led_bits_reg      <= led_bits_next;
            lit_count_reg     <= lit_count_next;
            tick_presc_reg    <= tick_presc_next;
            seconds_reg       <= seconds_next;
            tmo_presc_reg     <= tmo_presc_next;
            tmo_value_reg     <= tmo_value_next;
            pwm_period_reg    <= pwm_period_next;
            ticks_per_s_reg   <= ticks_per_s_next;
            tmo_presc_cfg_reg <= tmo_presc_cfg_next;
        end
    end

    // handshake and result ports
    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = (state_reg == S_IDLE);
    assign done           = done_reg;
    assign led_state      = led_bits_reg;
    assign leds_lit_count = lit_count_reg;
    assign timeout_left   = tmo_value_reg;
    assign power_off      = pulse_reg;

    // lit count tracks the number of running channels
    a_lit_matches_active: assert property (@(posedge clk) disable iff (!rst_n)
        lit_count_reg == LIT_W'($countones(chan_active_reg)))
        else $error("lit count out of step with active channels");

    // an accepted item always occupies the sequencer
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not start work");

    // a result transaction is only shown once the sequencer is back idle
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // the power-off pulse only comes with the seconds countdown at zero
    a_pulse_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && power_off |-> seconds_reg == '0)
        else $error("power-off pulse with seconds left");

endmodule

`default_nettype wire

@@ rtl/lpst_pattern_ram.sv @@
// lpst_pattern_ram: pattern table, one write and one registered read port
// depends on lpst_pkg for the word width
`timescale 1ns / 1ps
`default_nettype none

module lpst_pattern_ram
    import lpst_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/lpst_chan_alu.sv @@
// lpst_chan_alu: shared channel step unit, count increment and compares
// depends on lpst_pkg for lpst_alu_res_t
`timescale 1ns / 1ps
`default_nettype none

module lpst_chan_alu
    import lpst_pkg::*;
(
    input  wire logic [PERIOD_W-1:0] count,
    input  wire logic [PERIOD_W-1:0] on_time,
    input  wire logic [PERIOD_W-1:0] period,
    input  wire logic [ADDR_W-1:0]   addr,
    output lpst_alu_res_t            res
);

    logic [PERIOD_W-1:0] cnt_inc;

    assign cnt_inc      = count + PERIOD_W'(1);
    assign res.cnt_inc  = cnt_inc;
    assign res.addr_inc = addr + ADDR_W'(1);
    // led goes dark when the count meets the on-time
    assign res.hit_on   = (cnt_inc == on_time);
    // end of pwm period, fetch the next entry
    assign res.wrap     = (cnt_inc >= period);

endmodule

`default_nettype wire
